// ===== sv/encoder_velocity_estimator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// encoder velocity estimator assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ENCODER_VELOCITY_ESTIMATOR_UNIT_ASSERT_SVH
`define ENCODER_VELOCITY_ESTIMATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define EVU_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define EVU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/evu_pkg.sv =====
// ----------------------------------------------------------------------------
// evu_pkg
// Types and constants shared by the encoder velocity estimator modules.
// ----------------------------------------------------------------------------
package evu_pkg;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_REV   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_PERIOD_US = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT      = 2'd2;

    localparam logic [15:0] CPR_RESET    = 16'd13384;
    localparam logic [23:0] PERIOD_RESET = 24'd10000;
    localparam logic [7:0]  LIMIT_RESET  = 8'd3;

    // 360 degrees times one million microseconds per second
    localparam int          DEG_W     = 29;
    localparam logic [DEG_W-1:0] DEG_MICRO = 29'd360000000;

    // quotient bits produced by the divider
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic signed [31:0] position;
        logic        [31:0] time_us;
    } evu_in_t;

    typedef struct packed {
        logic signed [31:0] velocity;
        logic               forced_zero;
    } evu_out_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic prime;
        logic delta;
        logic mul;
        logic div_init;
        logic div_step;
        logic fin;
        logic report;
    } evu_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic primed;
        logic pos_changed;
        logic report_due;
        logic out_busy;
    } evu_sts_t;

endpackage

// ===== sv/evu_ctrl.sv =====
// ----------------------------------------------------------------------------
// evu_ctrl
// Sequencer for one item: prime, difference, multiply, divide, report.
// ----------------------------------------------------------------------------
module evu_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  evu_pkg::evu_sts_t sts,
    output evu_pkg::evu_cmd_t cmd
);
    import evu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DELTA,
        S_MUL,
        S_CHECK,
        S_DIV,
        S_FIN,
        S_REPORT
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DELTA;
                end
            end
            S_DELTA:
            begin
                if (!sts.primed)
                begin
                    cmd.prime  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (sts.pos_changed)
                begin
                    cmd.delta  = 1'b1;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_REPORT;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                if (!sts.report_due)
                begin
                    state_next = S_IDLE;
                end
                else if (!sts.out_busy)
                begin
                    cmd.report = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// ===== sv/evu_dp.sv =====
// ----------------------------------------------------------------------------
// evu_dp
// Registers, differences, multipliers, radix-2 divider and report logic.
// ----------------------------------------------------------------------------
module evu_dp #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [evu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [evu_pkg::CFG_W-1:0]       cfg_data,
    input  evu_pkg::evu_in_t                in_data,
    input  evu_pkg::evu_cmd_t               cmd,
    output evu_pkg::evu_sts_t               sts,
    output logic                            out_valid,
    input  logic                            out_stall,
    output evu_pkg::evu_out_t               out_data
);
    import evu_pkg::*;

    localparam int M_W   = 60;
    localparam int NUM_W = M_W + FRACTION_BITS;
    localparam int HI_W  = NUM_W - 32;
    localparam int DEN_W = 48;
    localparam int REM_W = DEN_W + 1;

    // configuration
    logic [15:0] cpr_reg;
    logic [23:0] period_reg;
    logic [7:0]  limit_reg;

    // tracking state
    logic        primed_reg;
    logic [31:0] last_pos_reg;
    logic [31:0] last_time_reg;
    logic [31:0] cur_vel_reg;
    logic [31:0] rep_vel_reg;
    logic [7:0]  stale_reg;
    logic [31:0] last_rep_reg;
    logic        out_valid_reg;

    // item and arithmetic registers
    logic [31:0]      item_pos_reg;
    logic [31:0]      item_time_reg;
    logic             neg_reg;
    logic [31:0]      mag_reg;
    logic [31:0]      dus_reg;
    logic [M_W-1:0]   m_reg;
    logic [DEN_W-1:0] den_reg;
    logic [REM_W-1:0] rem_reg;
    logic [31:0]      numlo_reg;
    logic [31:0]      q_reg;
    logic             sat_reg;
    evu_out_t         out_data_reg;

    logic [31:0]      dpos;
    logic [31:0]      dus;
    logic [15:0]      cpr_adj;
    logic [NUM_W-1:0] num;
    logic [HI_W-1:0]  num_hi;
    logic [REM_W-1:0] trial;
    logic             trial_ge;
    logic [31:0]      sat_max;
    logic [31:0]      q_sat;
    logic [31:0]      vel_new;
    logic [31:0]      since_rep;
    logic [7:0]       stale_next;
    logic [31:0]      rep_vel_next;
    logic             forced;

    // differences of the new sample against the stored one
    assign dpos    = item_pos_reg - last_pos_reg;
    assign dus     = item_time_reg - last_time_reg;
    assign cpr_adj = (cpr_reg == 16'd0) ? 16'd1 : cpr_reg;

    // scaled numerator and divider step
    assign num      = NUM_W'(m_reg) << FRACTION_BITS;
    assign num_hi   = num[NUM_W-1:32];
    assign trial    = {rem_reg[REM_W-2:0], numlo_reg[31]};
    assign trial_ge = (trial >= REM_W'(den_reg));

    // saturation and sign of the quotient
    assign sat_max = neg_reg ? 32'h8000_0000 : 32'h7fff_ffff;
    assign q_sat   = (sat_reg || (q_reg > sat_max)) ? sat_max : q_reg;
    assign vel_new = neg_reg ? (~q_sat + 32'd1) : q_sat;

    // stale check
    assign since_rep = item_time_reg - last_rep_reg;
    always_comb
    begin
        if (cur_vel_reg == rep_vel_reg)
        begin
            stale_next   = (stale_reg < limit_reg) ? (stale_reg + 8'd1) : stale_reg;
            rep_vel_next = rep_vel_reg;
        end
        else
        begin
            stale_next   = 8'd0;
            rep_vel_next = cur_vel_reg;
        end
    end
    assign forced = (stale_next >= limit_reg);

    // configuration and tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpr_reg       <= CPR_RESET;
            period_reg    <= PERIOD_RESET;
            limit_reg     <= LIMIT_RESET;
            primed_reg    <= 1'b0;
            last_pos_reg  <= '0;
            last_time_reg <= '0;
            cur_vel_reg   <= '0;
            rep_vel_reg   <= '0;
            stale_reg     <= '0;
            last_rep_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_COUNTS_PER_REV:   cpr_reg    <= cfg_data[15:0];
                    CFG_REPORT_PERIOD_US: period_reg <= cfg_data;
                    CFG_STALE_LIMIT:      limit_reg  <= cfg_data[7:0];
                    default:              ;
                endcase
            end
            if (cmd.prime)
            begin
                primed_reg    <= 1'b1;
                last_pos_reg  <= item_pos_reg;
                last_time_reg <= item_time_reg;
            end
            if (cmd.fin)
            begin
                cur_vel_reg   <= vel_new;
                last_pos_reg  <= item_pos_reg;
                last_time_reg <= item_time_reg;
            end
            if (cmd.report)
            begin
                stale_reg    <= stale_next;
                rep_vel_reg  <= rep_vel_next;
                last_rep_reg <= item_time_reg;
                if (forced)
                begin
                    cur_vel_reg <= '0;
                end
            end
            if (cmd.report)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // arithmetic pipeline and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_pos_reg  <= in_data.position;
            item_time_reg <= in_data.time_us;
        end
        if (cmd.delta)
        begin
            neg_reg <= dpos[31];
            mag_reg <= dpos[31] ? (~dpos + 32'd1) : dpos;
            dus_reg <= (dus == 32'd0) ? 32'd1 : dus;
        end
        if (cmd.mul)
        begin
            m_reg   <= M_W'(mag_reg) * M_W'(DEG_MICRO);
            den_reg <= DEN_W'(cpr_adj) * DEN_W'(dus_reg);
        end
        if (cmd.div_init)
        begin
            sat_reg   <= (REM_W'(num_hi) >= REM_W'(den_reg));
            rem_reg   <= REM_W'(num_hi);
            numlo_reg <= num[31:0];
            q_reg     <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg   <= trial_ge ? (trial - REM_W'(den_reg)) : trial;
            numlo_reg <= {numlo_reg[30:0], 1'b0};
            q_reg     <= {q_reg[30:0], trial_ge};
        end
        if (cmd.report)
        begin
            out_data_reg.velocity    <= forced ? 32'sd0 : $signed(cur_vel_reg);
            out_data_reg.forced_zero <= forced;
        end
    end

    // status to the controller
    assign sts.primed      = primed_reg;
    assign sts.pos_changed = (item_pos_reg != last_pos_reg);
    assign sts.report_due  = (since_rep >= {8'd0, period_reg});
    assign sts.out_busy    = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== sv/encoder_velocity_estimator_unit.sv =====
// ----------------------------------------------------------------------------
// encoder_velocity_estimator_unit
// Encoder velocity in degrees per second with periodic reports and a
// zero-speed timeout after repeated unchanged reports.
//
//   channel   direction  handshake          payload
//   in        input      in_valid/in_stall  position, time_us
//   out       output     out_valid/out_stall velocity, forced_zero
//   cfg       input      cfg_we             cfg_index, cfg_data
//
// A priming item passes idle and difference; an unchanged position adds report;
// a new one adds multiply, check, 32-step radix-2 divide, finish and report.
// A due report waits in its last step while the output register is held.
// The output register lets the next item in while a report is still held.
// Reset needs no clearing pass; the block is ready after reset.
// ----------------------------------------------------------------------------
`include "encoder_velocity_estimator_unit_assert.svh"

module encoder_velocity_estimator_unit #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [evu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [evu_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  evu_pkg::evu_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output evu_pkg::evu_out_t             out_data
);
    import evu_pkg::*;

    evu_cmd_t cmd;
    evu_sts_t sts;

    // controller
    evu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    evu_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // checks
    `EVU_ASSERT_IMPL(a_forced_is_zero, clk, rst_n, out_valid && out_data.forced_zero,
        out_data.velocity == 32'sd0, "forced report carries a nonzero velocity")
    `EVU_ASSERT_IMPL(a_report_from_work, clk, rst_n, $rose(out_valid),
        $past(in_stall), "report appeared without an item in progress")
    `EVU_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall,
        in_stall, "block still open for items right after accepting one")

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the encoder velocity estimator: directed samples
// around saturation, time wrap, zero intervals, stale timeout and register
// edge values, then random motion under several register settings, with
// random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import evu_pkg::*;

    localparam int          FRAC_BITS     = 8;
    localparam longint      DEG_US_PER_S  = 64'd360000000;
    localparam int          QUIET_LIMIT   = 4000;
    localparam int          SETTLE_CYCLES = 60;
    localparam int          REPORT_MAX    = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    evu_in_t              in_data;
    logic                 out_valid;
    logic                 out_stall;
    evu_out_t             out_data;

    encoder_velocity_estimator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // predictor registers and state
    logic [15:0] cpr_q;
    logic [23:0] period_q;
    logic [7:0]  limit_q;
    logic        primed_q;
    logic [31:0] last_pos_q;
    logic [31:0] last_time_q;
    logic [31:0] cur_vel_q;
    logic [31:0] rep_vel_q;
    logic [7:0]  stale_q;
    logic [31:0] last_rep_time_q;

    evu_out_t    pending_reports[$];
    evu_out_t    oldest_report;
    int          fail_count;
    int          quiet_cycles;
    int          hold_cycles;
    bit          gaps_on;

    // stimulus motion state
    logic [31:0] cur_pos;
    logic [31:0] cur_t;
    logic [31:0] step_dp;
    logic [31:0] step_dt;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // velocity in degrees per second, truncated and saturated
    function automatic logic [31:0] velocity_of(input logic [31:0] dpos,
                                                input logic [31:0] dus);
        logic        neg;
        logic [31:0] mag;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quo;
        neg = dpos[31];
        mag = neg ? (~dpos + 32'd1) : dpos;
        num = (128'(mag) * 128'(DEG_US_PER_S)) << FRAC_BITS;
        den = 128'((cpr_q == 16'd0) ? 16'd1 : cpr_q)
            * 128'((dus == 32'd0) ? 32'd1 : dus);
        quo = num / den;
        if (neg)
        begin
            if (quo > 128'h8000_0000)
                quo = 128'h8000_0000;
            return ~quo[31:0] + 32'd1;
        end
        if (quo > 128'h7FFF_FFFF)
            quo = 128'h7FFF_FFFF;
        return quo[31:0];
    endfunction

    // advance the predictor by one sample; returns 1 when a report is due
    function automatic bit report_for_sample(input evu_in_t s, output evu_out_t r);
        logic [31:0] pos;
        logic [31:0] t;
        pos = s.position;
        t   = s.time_us;
        r   = '0;
        if (!primed_q)
        begin
            primed_q    = 1'b1;
            last_pos_q  = pos;
            last_time_q = t;
            return 1'b0;
        end
        if (pos != last_pos_q)
        begin
            cur_vel_q   = velocity_of(pos - last_pos_q, t - last_time_q);
            last_pos_q  = pos;
            last_time_q = t;
        end
        if ((t - last_rep_time_q) < {8'd0, period_q})
            return 1'b0;
        if (cur_vel_q == rep_vel_q)
        begin
            if (stale_q < limit_q)
                stale_q = stale_q + 8'd1;
        end
        else
        begin
            stale_q   = 8'd0;
            rep_vel_q = cur_vel_q;
        end
        if (stale_q >= limit_q)
        begin
            cur_vel_q     = 32'd0;
            r.forced_zero = 1'b1;
        end
        last_rep_time_q = t;
        r.velocity      = cur_vel_q;
        return 1'b1;
    endfunction

    // stop offering items, wait for every report, then for any item in flight
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write while the block is idle
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_COUNTS_PER_REV:   cpr_q    = val[15:0];
            CFG_REPORT_PERIOD_US: period_q = val[23:0];
            CFG_STALE_LIMIT:      limit_q  = val[7:0];
            default: ;
        endcase
    endtask

    // offer one sample and wait for it to be taken
    task automatic send_sample(input logic [31:0] pos, input logic [31:0] t);
        evu_in_t  s;
        evu_out_t r;
        s.position = pos;
        s.time_us  = t;
        cur_pos    = pos;
        cur_t      = t;
        if (gaps_on)
        begin
            while ($urandom_range(0, 99) < 24)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        if (report_for_sample(s, r))
            pending_reports.push_back(r);
    endtask

    // random motion: mostly steady rates, with jumps, stops and noise
    task automatic motion_samples(input int n, input int unsigned span);
        int unsigned pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                step_dp = $urandom_range(0, 400) - 200;
                step_dt = $urandom_range(0, span);
            end
            if (pick < 60)
                send_sample(cur_pos + step_dp, cur_t + step_dt);
            else if (pick < 75)
                send_sample(cur_pos, cur_t + $urandom_range(0, span));
            else if (pick < 85)
                send_sample(cur_pos + $urandom_range(0, 4000) - 2000,
                            cur_t + $urandom_range(0, span));
            else if (pick < 92)
                send_sample($urandom(), cur_t + $urandom_range(0, span));
            else if (pick < 96)
                send_sample(cur_pos + step_dp, $urandom());
            else
                send_sample(cur_pos + step_dp, cur_t);
        end
    endtask

    // first sample primes, then both saturation limits and a zero interval
    task automatic test_priming_and_saturation();
        cfg_write(CFG_COUNTS_PER_REV, 24'd1);
        cfg_write(CFG_REPORT_PERIOD_US, 24'd0);
        cfg_write(CFG_STALE_LIMIT, 24'd255);
        send_sample(32'h0000_0000, 32'd100);
        send_sample(32'h7FFF_FFFF, 32'd101);
        send_sample(32'hFFFF_FFFF, 32'd101);
        send_sample(32'hFFFF_FFFF, 32'd300);
        send_sample(32'hFFFF_FFFE, 32'd301);
        send_sample(32'h0000_0100, 32'h0001_2345);
    endtask

    // timestamp wrap and the widest interval
    task automatic test_wrap_and_long_interval();
        cfg_write(CFG_COUNTS_PER_REV, 24'd65535);
        send_sample(32'h0000_0101, 32'hFFFF_FFF0);
        send_sample(32'h0000_0102, 32'h0000_0010);
        send_sample(32'h0000_0103, 32'h0000_000F);
        send_sample(32'h0000_0103, 32'h0000_000F);
    endtask

    // constant rate so reports repeat, then a zero limit
    task automatic test_stale_timeout();
        cfg_write(CFG_COUNTS_PER_REV, 24'd13384);
        cfg_write(CFG_REPORT_PERIOD_US, 24'd100);
        cfg_write(CFG_STALE_LIMIT, 24'd1);
        for (int i = 0; i < 4; i++)
            send_sample(cur_pos + 32'd50, cur_t + 32'd100);
        cfg_write(CFG_STALE_LIMIT, 24'd0);
        send_sample(cur_pos + 32'd50, cur_t + 32'd100);
        send_sample(cur_pos - 32'd9, cur_t + 32'd100);
    endtask

    // zero counts per rev, widest period, unused index
    task automatic test_register_edges();
        cfg_write(CFG_COUNTS_PER_REV, 24'hFF_0000);
        cfg_write(CFG_REPORT_PERIOD_US, 24'hFF_FFFF);
        cfg_write(CFG_STALE_LIMIT, 24'hAB_CDFF);
        cfg_write(CFG_UNUSED_IDX, 24'h5A_5A5A);
        send_sample(cur_pos + 32'd7, cur_t + 32'd1);
        send_sample(cur_pos + 32'd7, cur_t + 32'h0100_0000);
        cfg_write(CFG_REPORT_PERIOD_US, 24'd1);
        send_sample(cur_pos - 32'd3, cur_t + 32'd2);
    endtask

    // long output hold-off while samples keep coming
    task automatic test_output_backpressure();
        cfg_write(CFG_COUNTS_PER_REV, 24'd4096);
        cfg_write(CFG_REPORT_PERIOD_US, 24'd1);
        cfg_write(CFG_STALE_LIMIT, 24'd255);
        hold_cycles = 600;
        for (int i = 0; i < 25; i++)
            send_sample(cur_pos + $urandom_range(1, 500), cur_t + $urandom_range(1, 300));
    endtask

    // random motion under several register settings
    task automatic test_random_motion();
        cfg_write(CFG_COUNTS_PER_REV, 24'd13384);
        cfg_write(CFG_REPORT_PERIOD_US, 24'd10000);
        cfg_write(CFG_STALE_LIMIT, 24'd3);
        motion_samples(300, 4000);
        cfg_write(CFG_COUNTS_PER_REV, 24'd1);
        cfg_write(CFG_REPORT_PERIOD_US, 24'd1);
        cfg_write(CFG_STALE_LIMIT, 24'd1);
        motion_samples(300, 50);
        cfg_write(CFG_COUNTS_PER_REV, 24'd65535);
        cfg_write(CFG_REPORT_PERIOD_US, 24'hFF_FFFF);
        cfg_write(CFG_STALE_LIMIT, 24'd255);
        motion_samples(300, 8000000);
        cfg_write(CFG_COUNTS_PER_REV, {8'($urandom()), 16'($urandom_range(1, 65535))});
        cfg_write(CFG_REPORT_PERIOD_US, 24'($urandom_range(1, 2000)));
        cfg_write(CFG_STALE_LIMIT, {16'($urandom()), 8'($urandom_range(1, 6))});
        motion_samples(300, 800);
    endtask

    // back-to-back items with no idling on either side
    task automatic test_no_idle_stretch();
        cfg_write(CFG_REPORT_PERIOD_US, 24'd200);
        gaps_on = 1'b0;
        motion_samples(150, 150);
        gaps_on = 1'b1;
    endtask

    // output receiver: random stall, or a counted hold-off
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles = hold_cycles - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= gaps_on && ($urandom_range(0, 99) < 24);
        end
    end

    // compare each report with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected report: velocity %0d forced_zero %0b",
                             out_data.velocity, out_data.forced_zero);
            end
            else
            begin
                oldest_report = pending_reports.pop_front();
                if (out_data.velocity !== oldest_report.velocity
                    || out_data.forced_zero !== oldest_report.forced_zero)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("report mismatch: velocity exp %0d got %0d, %s%0b got %0b",
                                 oldest_report.velocity, out_data.velocity,
                                 "forced_zero exp ", oldest_report.forced_zero,
                                 out_data.forced_zero);
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", quiet_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // test sequence
    initial
    begin
        clk          = 1'b0;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        fail_count   = 0;
        quiet_cycles = 0;
        hold_cycles  = 0;
        gaps_on      = 1'b1;
        cpr_q           = CPR_RESET;
        period_q        = PERIOD_RESET;
        limit_q         = LIMIT_RESET;
        primed_q        = 1'b0;
        last_pos_q      = '0;
        last_time_q     = '0;
        cur_vel_q       = '0;
        rep_vel_q       = '0;
        stale_q         = '0;
        last_rep_time_q = '0;
        cur_pos         = '0;
        cur_t           = '0;
        step_dp         = 32'd20;
        step_dt         = 32'd1000;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_priming_and_saturation();
        test_wrap_and_long_interval();
        test_stale_timeout();
        test_register_edges();
        test_output_backpressure();
        test_random_motion();
        test_no_idle_stretch();

        drain();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/evu_pkg.sv
sv/evu_ctrl.sv
sv/evu_dp.sv
sv/encoder_velocity_estimator_unit.sv
dv/tb.sv
